FILE: sv/ppc_integer_execute_unit_top_defines.svh
// Assertion macros used by the execute unit back end
`ifndef PPC_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH
`define PPC_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define PIEU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset
`define PIEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: sv/pieu_pkg.sv
// Package: opcodes, payload structs and helpers for the integer execute unit
`timescale 1ns / 1ps
`default_nettype none
package pieu_pkg;
   typedef enum logic [5:0] {
      OP_MULLI = 6'd0, OP_SUBFIC = 6'd1, OP_ADDI = 6'd2, OP_ADDIC = 6'd3,
      OP_ADDICR = 6'd4, OP_ADDIS = 6'd5, OP_CMPI = 6'd6, OP_CMPLI = 6'd7,
      OP_CMP = 6'd8, OP_CMPL = 6'd9, OP_ORI = 6'd10, OP_ORIS = 6'd11,
      OP_XORI = 6'd12, OP_XORIS = 6'd13, OP_ANDI = 6'd14, OP_ANDIS = 6'd15,
      OP_ADD = 6'd16, OP_ADDC = 6'd17, OP_ADDE = 6'd18, OP_ADDME = 6'd19,
      OP_ADDZE = 6'd20, OP_SUBF = 6'd21, OP_SUBFC = 6'd22, OP_SUBFE = 6'd23,
      OP_SUBFME = 6'd24, OP_SUBFZE = 6'd25, OP_NEG = 6'd26, OP_MULLW = 6'd27,
      OP_MULHW = 6'd28, OP_MULHWU = 6'd29, OP_DIVW = 6'd30, OP_DIVWU = 6'd31,
      OP_AND = 6'd32, OP_ANDC = 6'd33, OP_OR = 6'd34, OP_ORC = 6'd35,
      OP_XOR = 6'd36, OP_NAND = 6'd37, OP_NOR = 6'd38, OP_EQV = 6'd39,
      OP_CNTLZW = 6'd40, OP_EXTSB = 6'd41, OP_EXTSH = 6'd42, OP_SLW = 6'd43,
      OP_SRW = 6'd44, OP_SRAW = 6'd45, OP_SRAWI = 6'd46, OP_RLWINM = 6'd47,
      OP_RLWNM = 6'd48, OP_RLWIMI = 6'd49
   } op_type;

   localparam int QDEPTH = 2;

   typedef struct packed {
      logic [5:0]  req_type;
      logic [4:0]  reg_ds;
      logic [4:0]  reg_a;
      logic [4:0]  reg_b;
      logic [15:0] immediate;
      logic [4:0]  shift_amount;
      logic [4:0]  mask_begin;
      logic [4:0]  mask_end;
      logic [2:0]  cr_field;
      logic        record;
      logic        overflow_enable;
   } req_type;

   typedef struct packed {
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        dest_write;
      logic [31:0] cond_value;
      logic        carry_out;
      logic        overflow_out;
      logic        summary_out;
   } rsp_type;

   // Decoded item handed from front to back
   typedef struct packed {
      req_type     req;
      logic        known;
      logic        is_div;
   } dec_type;

   function automatic logic [31:0] make_mask(input logic [4:0] mb, input logic [4:0] me);
      logic [31:0] m1, m2;
      begin
         m1 = 32'hFFFF_FFFF >> mb;
         m2 = (me == 5'd31) ? 32'd0 : (32'hFFFF_FFFF >> (me + 5'd1));
         make_mask = (mb <= me) ? (m1 & ~m2) : (m1 | ~m2);
      end
   endfunction
endpackage
`default_nettype wire

FILE: sv/pieu_front.sv
// Front end: accept items, classify them and queue them for the back end
`timescale 1ns / 1ps
`default_nettype none
module pieu_front import pieu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         q_valid,
   output dec_type      q_data,
   input  wire logic    q_take
);
   dec_type     q_ff [QDEPTH];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;
   dec_type     dec;

   // Classify the incoming item
   always_comb begin
      dec.req    = req_data;
      dec.known  = (req_data.req_type <= OP_RLWIMI);
      dec.is_div = (req_data.req_type == OP_DIVW) || (req_data.req_type == OP_DIVWU);
   end

   assign full    = (cnt_ff == 2'(QDEPTH));
   assign do_push = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign do_pop  = q_take && q_valid;
   assign q_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   // Advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (do_push) q_ff[wp_ff] <= dec;
   end
endmodule
`default_nettype wire

FILE: sv/pieu_divider.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pieu_divider import pieu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   assign trial = {r_ff, q_ff[31]} - {1'b0, d_ff};

   // Shift in one quotient bit a cycle
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; r_in = 32'd0; d_in = divisor; n_in = 6'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0]; q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]}; q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff + 6'd1;
         if (n_ff == 6'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

FILE: sv/pieu_back.sv
// Back end: register file, flags and execution of one item at a time
`timescale 1ns / 1ps
`default_nettype none
`include "ppc_integer_execute_unit_top_defines.svh"
module pieu_back import pieu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire dec_type q_data,
   output logic         q_take,
   output logic         rsp_empty,
   output rsp_type      rsp_data,
   input  wire logic    pop
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_EXEC = 5'b00010, ST_MUL = 5'b00100,
      ST_DIV = 5'b01000, ST_OUT = 5'b10000
   } st_type;

   st_type      st_ff, st_in;
   logic [31:0] rf_valid_ff, rf_valid_in;
   logic [31:0] rf [32];
   dec_type     cur_ff;
   logic [31:0] va_ff, vb_ff, vs_ff;
   logic [31:0] cr_ff, cr_in;
   logic        ca_ff, ca_in, ov_ff, ov_in, so_ff, so_in;
   rsp_type     out_ff, out_in;
   logic [63:0] prod_ff;
   logic [31:0] ma, mb;
   logic        msgn;
   logic [31:0] div_a, div_b, quot;
   logic        div_start, div_done, div_neg;
   logic        wr_en;

   op_type      op;
   logic [31:0] simm, res, mask, rot, x, n, tmp;
   logic [32:0] wide;
   logic [5:0]  sh6;
   logic [4:0]  dst;
   logic        wr, rec, has_oe, ov, ca_new, bad_div;
   logic [3:0]  bits;
   logic [2:0]  fld;
   logic        so_new;
   logic [63:0] prod_s;

   assign q_take = (st_ff == ST_IDLE) && q_valid;
   assign op = op_type'(cur_ff.req.req_type);

   // Multiplier operands: signed magnitude, unsigned product
   always_comb begin
      tmp = (op == OP_MULLI) ? {{16{cur_ff.req.immediate[15]}}, cur_ff.req.immediate}
            : vb_ff;
      if (op == OP_MULHWU) begin
         ma = va_ff; mb = vb_ff; msgn = 1'b0;
      end else begin
         ma = va_ff[31] ? (~va_ff + 32'd1) : va_ff;
         mb = tmp[31] ? (~tmp + 32'd1) : tmp;
         msgn = va_ff[31] ^ tmp[31];
      end
   end

   // Divider operands
   always_comb begin
      if (op == OP_DIVW) begin
         div_a = va_ff[31] ? (~va_ff + 32'd1) : va_ff;
         div_b = vb_ff[31] ? (~vb_ff + 32'd1) : vb_ff;
         div_neg = va_ff[31] ^ vb_ff[31];
      end else begin
         div_a = va_ff; div_b = vb_ff; div_neg = 1'b0;
      end
   end
   assign div_start = (st_ff == ST_EXEC) && cur_ff.is_div;

   pieu_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(quot)
   );

   assign prod_s = msgn ? (~prod_ff + 64'd1) : prod_ff;

   // Compute result from operands, product and quotient
   always_comb begin
      simm = {{16{cur_ff.req.immediate[15]}}, cur_ff.req.immediate};
      res = 32'd0; dst = cur_ff.req.reg_ds; wr = 1'b1; rec = 1'b0; has_oe = 1'b0;
      ov = 1'b0; ca_new = ca_ff; wide = 33'd0; x = 32'd0; n = 32'd0;
      mask = make_mask(cur_ff.req.mask_begin, cur_ff.req.mask_end);
      rot = 32'd0; sh6 = 6'd0; bad_div = 1'b0;
      cr_in = cr_ff; so_new = so_ff; bits = 4'd0; fld = 3'd0;
      unique case (op)
         OP_MULLI: res = prod_s[31:0];
         OP_SUBFIC: begin
            wide = {1'b0, simm} + {1'b0, ~va_ff} + 33'd1;
            res = wide[31:0]; ca_new = wide[32];
         end
         OP_ADDI: res = ((cur_ff.req.reg_a == 5'd0) ? 32'd0 : va_ff) + simm;
         OP_ADDIC, OP_ADDICR: begin
            wide = {1'b0, va_ff} + {1'b0, simm};
            res = wide[31:0]; ca_new = wide[32]; rec = (op == OP_ADDICR);
         end
         OP_ADDIS: res = ((cur_ff.req.reg_a == 5'd0) ? 32'd0 : va_ff) + {simm[15:0], 16'd0};
         OP_CMPI, OP_CMPLI, OP_CMP, OP_CMPL: wr = 1'b0;
         OP_ORI:   begin dst = cur_ff.req.reg_a; res = vs_ff | {16'd0, cur_ff.req.immediate}; end
         OP_ORIS:  begin dst = cur_ff.req.reg_a; res = vs_ff | {cur_ff.req.immediate, 16'd0}; end
         OP_XORI:  begin dst = cur_ff.req.reg_a; res = vs_ff ^ {16'd0, cur_ff.req.immediate}; end
         OP_XORIS: begin dst = cur_ff.req.reg_a; res = vs_ff ^ {cur_ff.req.immediate, 16'd0}; end
         OP_ANDI: begin
            dst = cur_ff.req.reg_a; res = vs_ff & {16'd0, cur_ff.req.immediate}; rec = 1'b1;
         end
         OP_ANDIS: begin
            dst = cur_ff.req.reg_a; res = vs_ff & {cur_ff.req.immediate, 16'd0}; rec = 1'b1;
         end
         OP_ADD, OP_SUBF: begin
            x = (op == OP_SUBF) ? ~va_ff : va_ff;
            res = x + vb_ff + ((op == OP_SUBF) ? 32'd1 : 32'd0);
            ov = (x[31] ^ res[31]) & (vb_ff[31] ^ res[31]);
            has_oe = 1'b1; rec = cur_ff.req.record;
         end
         OP_ADDC, OP_ADDE, OP_ADDME, OP_ADDZE,
         OP_SUBFC, OP_SUBFE, OP_SUBFME, OP_SUBFZE: begin
            x = (op >= OP_SUBFC) ? ~va_ff : va_ff;
            if (op == OP_ADDC || op == OP_ADDE || op == OP_SUBFC || op == OP_SUBFE) n = vb_ff;
            else if (op == OP_ADDME || op == OP_SUBFME) n = 32'hFFFF_FFFF;
            else n = 32'd0;
            wide = {1'b0, x} + {1'b0, n} + ((op == OP_ADDC) ? 33'd0 :
                   (op == OP_SUBFC) ? 33'd1 : {32'd0, ca_ff});
            res = wide[31:0]; ca_new = wide[32];
            ov = (x[31] ^ res[31]) & (n[31] ^ res[31]);
            has_oe = 1'b1; rec = cur_ff.req.record;
         end
         OP_NEG: begin
            res = ~va_ff + 32'd1; ov = (va_ff == 32'h8000_0000);
            has_oe = 1'b1; rec = cur_ff.req.record;
         end
         OP_MULLW: begin
            res = prod_s[31:0];
            ov = (prod_s[63:31] != {33{1'b0}}) && (prod_s[63:31] != {33{1'b1}});
            has_oe = 1'b1; rec = cur_ff.req.record;
         end
         OP_MULHW, OP_MULHWU: begin res = prod_s[63:32]; rec = cur_ff.req.record; end
         OP_DIVW: begin
            bad_div = (vb_ff == 32'd0) || (va_ff == 32'h8000_0000 && vb_ff == 32'hFFFF_FFFF);
            ov = bad_div;
            res = bad_div ? {32{va_ff[31]}} : (div_neg ? (~quot + 32'd1) : quot);
            has_oe = 1'b1; rec = cur_ff.req.record;
         end
         OP_DIVWU: begin
            ov = (vb_ff == 32'd0); res = ov ? 32'd0 : quot;
            has_oe = 1'b1; rec = cur_ff.req.record;
         end
         OP_AND:  begin dst = cur_ff.req.reg_a; res = vs_ff & vb_ff;     rec = cur_ff.req.record; end
         OP_ANDC: begin dst = cur_ff.req.reg_a; res = vs_ff & ~vb_ff;    rec = cur_ff.req.record; end
         OP_OR:   begin dst = cur_ff.req.reg_a; res = vs_ff | vb_ff;     rec = cur_ff.req.record; end
         OP_ORC:  begin dst = cur_ff.req.reg_a; res = vs_ff | ~vb_ff;    rec = cur_ff.req.record; end
         OP_XOR:  begin dst = cur_ff.req.reg_a; res = vs_ff ^ vb_ff;     rec = cur_ff.req.record; end
         OP_NAND: begin dst = cur_ff.req.reg_a; res = ~(vs_ff & vb_ff);  rec = cur_ff.req.record; end
         OP_NOR:  begin dst = cur_ff.req.reg_a; res = ~(vs_ff | vb_ff);  rec = cur_ff.req.record; end
         OP_EQV:  begin dst = cur_ff.req.reg_a; res = ~(vs_ff ^ vb_ff);  rec = cur_ff.req.record; end
         OP_CNTLZW: begin
            dst = cur_ff.req.reg_a; rec = cur_ff.req.record; res = 32'd32;
            for (int i = 0; i < 32; i++) begin
               if (vs_ff[i]) res = 32'(31 - i);
            end
         end
         OP_EXTSB: begin
            dst = cur_ff.req.reg_a; rec = cur_ff.req.record;
            res = {{24{vs_ff[7]}}, vs_ff[7:0]};
         end
         OP_EXTSH: begin
            dst = cur_ff.req.reg_a; rec = cur_ff.req.record;
            res = {{16{vs_ff[15]}}, vs_ff[15:0]};
         end
         OP_SLW, OP_SRW: begin
            dst = cur_ff.req.reg_a; rec = cur_ff.req.record; sh6 = vb_ff[5:0];
            res = sh6[5] ? 32'd0 : ((op == OP_SLW) ? (vs_ff << sh6[4:0]) : (vs_ff >> sh6[4:0]));
         end
         OP_SRAW, OP_SRAWI: begin
            dst = cur_ff.req.reg_a; rec = cur_ff.req.record;
            sh6 = (op == OP_SRAWI) ? {1'b0, cur_ff.req.shift_amount} : vb_ff[5:0];
            if (sh6 == 6'd0) begin
               res = vs_ff; ca_new = 1'b0;
            end else if (sh6[5]) begin
               res = {32{vs_ff[31]}}; ca_new = vs_ff[31];
            end else begin
               res = 32'($signed(vs_ff) >>> sh6[4:0]);
               ca_new = vs_ff[31] && ((vs_ff << (6'd32 - sh6)) != 32'd0);
            end
         end
         OP_RLWINM, OP_RLWNM, OP_RLWIMI: begin
            dst = cur_ff.req.reg_a; rec = cur_ff.req.record;
            sh6 = (op == OP_RLWNM) ? {1'b0, vb_ff[4:0]} : {1'b0, cur_ff.req.shift_amount};
            rot = (vs_ff << sh6[4:0]) | (vs_ff >> (6'd32 - sh6));
            if (sh6 == 6'd0) rot = vs_ff;
            res = (op == OP_RLWIMI) ? ((va_ff & ~mask) | (rot & mask)) : (rot & mask);
         end
         default: wr = 1'b0;
      endcase
      if (!cur_ff.known) begin
         wr = 1'b0; ca_new = ca_ff;
      end
      // Overflow then condition fields
      ov_in = ov_ff;
      if (has_oe && cur_ff.req.overflow_enable && cur_ff.known) begin
         ov_in = ov; so_new = so_ff | ov;
      end
      if (cur_ff.known && (op == OP_CMPI || op == OP_CMP)) begin
         x = (op == OP_CMPI) ? simm : vb_ff;
         bits = ($signed(va_ff) < $signed(x)) ? 4'd8 : (($signed(va_ff) > $signed(x)) ? 4'd4 : 4'd2);
         fld = cur_ff.req.cr_field;
      end else if (cur_ff.known && (op == OP_CMPLI || op == OP_CMPL)) begin
         x = (op == OP_CMPLI) ? {16'd0, cur_ff.req.immediate} : vb_ff;
         bits = (va_ff < x) ? 4'd8 : ((va_ff > x) ? 4'd4 : 4'd2);
         fld = cur_ff.req.cr_field;
      end else if (wr && rec) begin
         bits = res[31] ? 4'd8 : ((res != 32'd0) ? 4'd4 : 4'd2);
      end
      if (bits != 4'd0) begin
         cr_in = cr_ff;
         cr_in[5'd28 - {fld, 2'b00} +: 4] = bits | {3'd0, so_new};
      end
      ca_in = ca_new; so_in = so_new;
      out_in.dest_index   = wr ? dst : 5'd0;
      out_in.dest_value   = wr ? res : 32'd0;
      out_in.dest_write   = wr;
      out_in.cond_value   = cr_in;
      out_in.carry_out    = ca_in;
      out_in.overflow_out = ov_in;
      out_in.summary_out  = so_in;
   end

   // Sequence one item: exec, optional multiply or divide wait, then present
   always_comb begin
      st_in = st_ff; wr_en = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (q_valid) st_in = ST_EXEC;
         ST_EXEC: begin
            if (cur_ff.is_div) st_in = ST_DIV;
            else if (op == OP_MULLI || op == OP_MULLW || op == OP_MULHW || op == OP_MULHWU)
               st_in = ST_MUL;
            else begin st_in = ST_OUT; wr_en = 1'b1; end
         end
         ST_MUL: begin st_in = ST_OUT; wr_en = 1'b1; end
         ST_DIV: if (div_done) begin st_in = ST_OUT; wr_en = 1'b1; end
         ST_OUT: if (pop) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rf_valid_in = rf_valid_ff;
      if (wr_en && wr) rf_valid_in[dst] = 1'b1;
   end

   // Control and architected flags
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rf_valid_ff <= 32'd0; cr_ff <= 32'd0;
         ca_ff <= 1'b0; ov_ff <= 1'b0; so_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rf_valid_ff <= rf_valid_in;
         if (wr_en) begin
            cr_ff <= cr_in; ca_ff <= ca_in; ov_ff <= ov_in; so_ff <= so_in;
         end
      end
   end

   // Payload registers and register file access; valid bits give the zero reset value
   always_ff @(posedge clock) begin
      if (q_take) begin
         cur_ff <= q_data;
         va_ff <= rf_valid_ff[q_data.req.reg_a]  ? rf[q_data.req.reg_a]  : 32'd0;
         vb_ff <= rf_valid_ff[q_data.req.reg_b]  ? rf[q_data.req.reg_b]  : 32'd0;
         vs_ff <= rf_valid_ff[q_data.req.reg_ds] ? rf[q_data.req.reg_ds] : 32'd0;
      end
      prod_ff <= {32'd0, ma} * {32'd0, mb};
      if (wr_en) begin
         out_ff <= out_in;
         if (wr) rf[dst] <= res;
      end
   end

   assign rsp_empty = (st_ff != ST_OUT);
   assign rsp_data  = out_ff;

   `PIEU_ASSERT_IMP(a_take_idle, clock, reset, q_take, st_ff == ST_IDLE, "take outside idle")
   `PIEU_ASSERT_NEXT(a_out_hold, clock, reset, (st_ff == ST_OUT) && !pop, st_ff == ST_OUT,
      "result dropped")
   `PIEU_ASSERT_IMP(a_so_sticky, clock, reset, $past(so_ff) && !$past(reset), so_ff,
      "summary overflow cleared")
endmodule
`default_nettype wire

FILE: sv/ppc_integer_execute_unit_top.sv
// Flow: the front queues each item; the back end takes it, executes it, waits in ST_MUL for
// multiplies or in ST_DIV for divides, then holds the result until pop. Throughput: one item
// at a time in the back end; the radix-2 divider (32 steps) sets the divide time.
// A two-entry queue lets the front accept while the back works.
// Reset (synchronous, active high) clears CR and XER bits; registers read as zero via valid bits.
`timescale 1ns / 1ps
`default_nettype none
module ppc_integer_execute_unit_top import pieu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);
   logic    q_valid, q_take;
   dec_type q_data;

   pieu_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
   );

   pieu_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data), .q_take(q_take),
      .rsp_empty(empty), .rsp_data(rsp_data), .pop(pop)
   );
endmodule
`default_nettype wire
